// ===== hdl/keypad_debounce_sequence_assert.svh =====
// Assertion macros for the keypad block. Simulation builds check them;
// synthesis builds see empty bodies.
`ifndef KEYPAD_DEBOUNCE_SEQUENCE_ASSERT_SVH
`define KEYPAD_DEBOUNCE_SEQUENCE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked at every rising edge, skipped while reset is held.
`define KDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define KDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KDS_ASSERT(lbl, prop, msg)
`define KDS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/kds_pkg.sv =====
`default_nettype none

package kds_pkg;

  localparam int unsigned ROW_W = 4;
  localparam int unsigned COL_W = 3;
  localparam int unsigned KEY_W = 8;
  localparam int unsigned POS_W = 6;
  localparam int unsigned SETTLE_W = 8;
  localparam int unsigned SEQ_LEN_W = 7;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN = 1'b1;

  localparam logic [SETTLE_W-1:0]  SETTLE_RESET  = 8'd7;
  localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RESET = 7'd6;
  localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_MAX   = 7'd64;

  // Depth of the event queue between the debouncer and the sequencer.
  localparam int unsigned KDS_Q_DEPTH = 4;
  localparam int unsigned KDS_Q_AW = $clog2(KDS_Q_DEPTH);
  localparam int unsigned KDS_Q_CW = $clog2(KDS_Q_DEPTH + 1);

  typedef logic [KEY_W-1:0] key_char_t;

  localparam key_char_t KEY_NONE = 8'h00;
  localparam key_char_t KEY_ZERO = 8'h30;
  localparam key_char_t KEY_ONE  = 8'h31;

  typedef struct packed {
    logic [KDS_Q_CW-1:0] count;
    logic                full;
    logic                empty;
  } kds_q_status_t;

  // Position of the single set bit, counted from 1; 0 when not one-hot.
  function automatic logic [2:0] one_hot_index(input logic [3:0] v);
    logic [2:0] idx;
    unique case (v)
      4'b0001: idx = 3'd1;
      4'b0010: idx = 3'd2;
      4'b0100: idx = 3'd3;
      4'b1000: idx = 3'd4;
      default: idx = 3'd0;
    endcase
    return idx;
  endfunction

  function automatic key_char_t decode_key(input logic [ROW_W-1:0] rows,
                                           input logic [COL_W-1:0] cols);
    logic [2:0] r;
    logic [2:0] c;
    logic [3:0] r4;
    logic [3:0] c4;
    logic [3:0] idx;
    key_char_t  key;
    r   = one_hot_index(~rows);
    c   = one_hot_index({1'b0, ~cols});
    r4  = {1'b0, r};
    c4  = {1'b0, c};
    // 3*(row-1) + (col-1)
    idx = (r4 << 1) + r4 + c4 - 4'd4;
    if (r == 3'd0 || c == 3'd0) begin
      key = KEY_NONE;
    end else if (r == 3'd4 && c == 3'd2) begin
      key = KEY_ZERO;
    end else begin
      key = KEY_ONE + {4'b0000, idx};
    end
    return key;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/kds_if.sv =====
`default_nettype none

interface kds_in_if
  import kds_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   row_pins;
  logic [COL_W-1:0]   col_pins;

  modport source (output valid, output row_pins, output col_pins, input ready);
  modport sink   (input valid, input row_pins, input col_pins, output ready);
endinterface

interface kds_out_if
  import kds_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   key_char;
  logic [POS_W-1:0]   key_position;
  logic               last_of_sequence;

  modport source (output valid, output key_char, output key_position,
                  output last_of_sequence, input ready);
  modport sink   (input valid, input key_char, input key_position,
                  input last_of_sequence, output ready);
endinterface

`default_nettype wire

// ===== hdl/kds_front.sv =====
`default_nettype none

module kds_front
  import kds_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  kds_in_if.sink                   in_ch,
  input  wire logic [SETTLE_W-1:0] settle_count,
  input  wire kds_q_status_t       q_status,
  output logic                     push,
  output key_char_t                push_key
);

  logic                fresh_r, fresh_nxt;
  key_char_t           prev_key_r, prev_key_nxt;
  logic [SETTLE_W-1:0] eq_cnt_r, eq_cnt_nxt;
  key_char_t           key;
  logic                accept;
  logic                stable;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign key         = decode_key(in_ch.row_pins, in_ch.col_pins);

  always_comb begin
    fresh_nxt    = fresh_r;
    prev_key_nxt = prev_key_r;
    eq_cnt_nxt   = eq_cnt_r;
    stable       = 1'b0;
    if (accept) begin
      if (fresh_r) begin
        // The first sample of a window sets the reference key; with a settle count of 0 it also completes the window.
        prev_key_nxt = key;
        eq_cnt_nxt   = '0;
        fresh_nxt    = 1'b0;
        stable       = (settle_count == '0);
      end else begin
        eq_cnt_nxt   = (key == prev_key_r) ? eq_cnt_r + 1'b1 : '0;
        prev_key_nxt = key;
        stable       = (eq_cnt_nxt == settle_count);
      end
      if (stable) begin
        fresh_nxt = 1'b1;
      end
    end
  end

  assign push     = stable;
  assign push_key = key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r    <= 1'b1;
      prev_key_r <= KEY_NONE;
      eq_cnt_r   <= '0;
    end else begin
      fresh_r    <= fresh_nxt;
      prev_key_r <= prev_key_nxt;
      eq_cnt_r   <= eq_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kds_fifo.sv =====
`default_nettype none

module kds_fifo
  import kds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire key_char_t push_data,
  input  wire logic      pop,
  output key_char_t      pop_data,
  output kds_q_status_t  status
);

  localparam logic [KDS_Q_AW-1:0] LAST_SLOT = KDS_Q_AW'(KDS_Q_DEPTH - 1);
  localparam logic [KDS_Q_CW-1:0] FULL_CNT  = KDS_Q_CW'(KDS_Q_DEPTH);

  key_char_t           mem_r [KDS_Q_DEPTH];
  logic [KDS_Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [KDS_Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [KDS_Q_CW-1:0] count_r, count_nxt;

  assign pop_data     = mem_r[rd_ptr_r];
  assign status.count = count_r;
  assign status.full  = (count_r == FULL_CNT);
  assign status.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kds_back.sv =====
`default_nettype none

module kds_back
  import kds_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [SEQ_LEN_W-1:0] sequence_length,
  input  wire kds_q_status_t        q_status,
  input  wire key_char_t            q_key,
  output logic                      pop,
  kds_out_if.source                 out_ch
);

  logic                 awaiting_r;
  key_char_t            held_key_r;
  logic [POS_W-1:0]     pos_r;
  logic                 out_valid_r;
  key_char_t            out_key_r;
  logic [POS_W-1:0]     out_pos_r;
  logic                 out_last_r;
  logic                 emits;
  logic                 slot_free;
  logic [SEQ_LEN_W-1:0] len;
  logic [SEQ_LEN_W-1:0] next_pos;
  logic                 last;

  // A stable release while a key is held is the only event that yields an item.
  assign emits     = awaiting_r && (q_key == KEY_NONE);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign pop       = !q_status.empty && (!emits || slot_free);

  always_comb begin
    if (sequence_length == '0) begin
      len = SEQ_LEN_W'(1);
    end else if (sequence_length > SEQ_LEN_MAX) begin
      len = SEQ_LEN_MAX;
    end else begin
      len = sequence_length;
    end
  end

  assign next_pos = {1'b0, pos_r} + 1'b1;
  assign last     = (next_pos >= len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r  <= 1'b0;
      held_key_r  <= KEY_NONE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && emits) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        if (!awaiting_r && q_key != KEY_NONE) begin
          awaiting_r <= 1'b1;
          held_key_r <= q_key;
        end else if (emits) begin
          awaiting_r <= 1'b0;
          pos_r      <= last ? '0 : next_pos[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      out_key_r  <= held_key_r;
      out_pos_r  <= pos_r;
      out_last_r <= last;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.key_char         = out_key_r;
  assign out_ch.key_position     = out_pos_r;
  assign out_ch.last_of_sequence = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/keypad_debounce_sequence.sv =====
// Keypad scanner for a 4x3 matrix with debounce and key sequencing.
// in_ch carries one sample of the active-low row and column pins per item;
// one item is taken every clock cycle while in_ch.ready is high.
// out_ch carries one item per pressed-and-released key: the key's ASCII code,
// its position in the sequence and a mark on the key that ends the sequence.
// The cfg port writes the settle count (index 0) and the sequence length
// (index 1); write them only while the block is idle.
// With the queue empty and out_ch free, the sample that completes a stable
// release is written into the queue, and its item is then registered onto out_ch.
// Throughput is one sample per cycle while in_ch.ready is high, set by the debouncer
// taking one sample and the sequencer retiring one queued event per cycle while out_ch is free.
// When out_ch stalls, debounce events gather in a four-entry queue and
// in_ch.ready falls only once that queue is full.
// Synchronous reset (rst_n low) returns the debouncer to a fresh window, the
// sequencer to waiting for a press at position 0, empties the queue and loads
// a settle count of 7 and a sequence length of 6.
`default_nettype none

`include "keypad_debounce_sequence_assert.svh"

module keypad_debounce_sequence
  import kds_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  kds_in_if.sink                     in_ch,
  kds_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SETTLE_W-1:0]  settle_r;
  logic [SEQ_LEN_W-1:0] seq_len_r;
  kds_q_status_t        q_status;
  logic                 push;
  key_char_t            push_key;
  logic                 pop;
  key_char_t            q_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r  <= SETTLE_RESET;
      seq_len_r <= SEQ_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SETTLE:  settle_r  <= cfg_data[SETTLE_W-1:0];
        CFG_SEQ_LEN: seq_len_r <= cfg_data[SEQ_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  kds_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .settle_count (settle_r),
    .q_status     (q_status),
    .push         (push),
    .push_key     (push_key)
  );

  kds_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_key),
    .pop       (pop),
    .pop_data  (q_key),
    .status    (q_status)
  );

  kds_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .sequence_length (seq_len_r),
    .q_status        (q_status),
    .q_key           (q_key),
    .pop             (pop),
    .out_ch          (out_ch)
  );

  `KDS_ASSERT(a_q_bound, (q_status.count <= KDS_Q_CW'(KDS_Q_DEPTH)), "queue overfilled")
  `KDS_ASSERT(a_q_push_room, (push |-> !q_status.full), "push into a full queue")
  `KDS_ASSERT(a_out_key_set, (out_ch.valid |-> out_ch.key_char != KEY_NONE), "item without key")
  `KDS_ASSERT(a_pos_range, (out_ch.valid && !out_ch.last_of_sequence |-> out_ch.key_position != 6'd63), "position past end")

endmodule

`default_nettype wire
